// ----- design/knnd_pkg.sv -----
// ---------------------------------------------------------------------------
// knnd_pkg
// Shared types and constants for the k-th nearest neighbor distance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package knnd_pkg;

    // result distance width
    localparam int DIST_W = 35;

    // opcodes carried on the input tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_POINTS = 2'd0;
    localparam logic [1:0] CFG_NUM_DIMS   = 2'd1;
    localparam logic [1:0] CFG_K_RANK     = 2'd2;
    localparam logic [1:0] CFG_NORM_MODE  = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic q_start;     // latch query index, read the query row
        logic q_row;       // capture the query row from the store
        logic pass_start;  // rewind the scan counter, clear the running minimum
        logic issue;       // read the next candidate point
        logic pass_end;    // commit the running minimum as the new rank
        logic out_load;    // load the result register
        logic out_found;   // result is a valid distance
    } knnd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic q_bad;       // query can not return a distance
        logic scan_more;   // candidates remain in this pass
        logic pipe_empty;  // distance pipeline drained
        logic hold_valid;  // running minimum holds a candidate
    } knnd_status_t;

endpackage

`default_nettype wire

// ----- design/knnd_ram.sv -----
// ---------------------------------------------------------------------------
// knnd_ram
// Simple dual port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/knnd_ctrl.sv -----
// ---------------------------------------------------------------------------
// knnd_ctrl
// Query sequencer: query row fetch, up to k scan passes, result handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knnd_ctrl #(
    parameter int MAX_K = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_op,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    input  wire logic [4:0]              k_rank,
    input  wire knnd_pkg::knnd_status_t  status,
    output knnd_pkg::knnd_cmd_t          cmd
);

    import knnd_pkg::*;

    localparam int PK_W = $clog2(MAX_K + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QROW  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [PK_W-1:0] pass_reg, pass_next;
    logic            found_reg, found_next;
    logic            out_valid_reg, out_valid_next;
    logic [PK_W-1:0] k_eff;
    logic [PK_W-1:0] pass_inc;

    assign k_eff    = (32'(k_rank) > MAX_K) ? PK_W'(MAX_K) : PK_W'(k_rank);
    assign pass_inc = pass_reg + 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        pass_next      = pass_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_op == OP_QUERY)
                begin
                    cmd.q_start = 1'b1;
                    if (status.q_bad)
                    begin
                        found_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_QROW;
                    end
                end
            end
            S_QROW:
            begin
                cmd.q_row      = 1'b1;
                cmd.pass_start = 1'b1;
                pass_next      = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    cmd.pass_end = 1'b1;
                    if (!status.hold_valid)
                    begin
                        found_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (pass_inc == k_eff)
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pass_next      = pass_inc;
                        cmd.pass_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                // wait until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_found  = found_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/knnd_dp.sv -----
// ---------------------------------------------------------------------------
// knnd_dp
// Point store, distance pipeline and rank tracking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knnd_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 8,
    parameter int COORD_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_accept,
    input  wire logic                    in_op,
    input  wire logic [9:0]              point_index,
    input  wire logic [2:0]              dim_index,
    input  wire logic signed [15:0]      coord,
    input  wire logic [10:0]             num_points,
    input  wire logic [3:0]              num_dims,
    input  wire logic [4:0]              k_rank,
    input  wire logic                    norm_mode,
    input  wire knnd_pkg::knnd_cmd_t     cmd,
    output knnd_pkg::knnd_status_t       status,
    output logic [knnd_pkg::DIST_W-1:0]  distance,
    output logic                         found
);

    import knnd_pkg::*;

    localparam int PA_W  = $clog2(MAX_POINTS);
    localparam int PC_W  = $clog2(MAX_POINTS + 1);
    localparam int DF_W  = COORD_BITS + 1;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int ACC_W = SQ_W + $clog2(MAX_DIMS);
    localparam int EXT_W = (ACC_W > DIST_W) ? ACC_W : DIST_W;

    // decoded input
    logic [31:0]           pt32;
    logic [PA_W-1:0]       pt_addr;
    logic                  pt_in_range;
    logic signed [31:0]    coord_sx;
    logic [COORD_BITS-1:0] wr_data;
    logic                  load_en;
    logic [PC_W-1:0]       npts;
    logic [PA_W-1:0]       rd_addr;

    logic [COORD_BITS-1:0] rd_data   [MAX_DIMS];
    logic [COORD_BITS-1:0] q_row_reg [MAX_DIMS];
    logic [COORD_BITS-1:0] ab1_reg   [MAX_DIMS];
    logic [SQ_W-1:0]       sq2_reg   [MAX_DIMS];
    logic [MAX_DIMS-1:0]   dim_active;

    logic [9:0]      qpt_reg;
    logic [PC_W-1:0] j_reg;
    logic            v0_reg, v1_reg, v2_reg, v3_reg;
    logic            skip0_reg, skip1_reg, skip2_reg, skip3_reg;
    logic [ACC_W-1:0] acc3_reg;
    logic [ACC_W-1:0] acc_comb;
    logic [ACC_W-1:0] hold_reg;
    logic             hold_valid_reg;
    logic [ACC_W-1:0] prev_reg;
    logic             have_prev_reg;
    logic             take;
    logic [EXT_W-1:0] prev_ext;
    logic [DIST_W-1:0] dist_sat;
    logic [DIST_W-1:0] distance_reg;
    logic              found_reg;

    assign pt32        = 32'(point_index);
    assign pt_addr     = pt32[PA_W-1:0];
    assign pt_in_range = pt32 < MAX_POINTS;
    assign coord_sx    = 32'(coord);
    assign wr_data     = coord_sx[COORD_BITS-1:0];
    assign load_en     = in_accept && in_op == OP_LOAD && pt_in_range;
    assign npts        = (32'(num_points) > MAX_POINTS) ? PC_W'(MAX_POINTS)
                                                         : PC_W'(num_points);
    assign rd_addr     = cmd.q_start ? pt_addr : j_reg[PA_W-1:0];

    // one store per dimension so all dimensions of a point are read together
    for (genvar l = 0; l < MAX_DIMS; l++)
    begin : g_dim
        knnd_ram #(
            .WIDTH (COORD_BITS),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (load_en && 32'(dim_index) == 32'(l)),
            .waddr (pt_addr),
            .wdata (wr_data),
            .raddr (rd_addr),
            .rdata (rd_data[l])
        );
        assign dim_active[l] = 32'(num_dims) > 32'(l);
    end

    assign status.q_bad      = !pt_in_range || k_rank == 5'd0;
    assign status.scan_more  = 32'(j_reg) < 32'(npts);
    assign status.pipe_empty = !(v0_reg || v1_reg || v2_reg || v3_reg);
    assign status.hold_valid = hold_valid_reg;

    // per-dimension difference, magnitude and, unless norm_mode is set, square
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MAX_DIMS; l++)
        begin
            logic [DF_W-1:0] diff;
            logic [DF_W-1:0] mag;
            diff = {rd_data[l][COORD_BITS-1], rd_data[l]}
                 - {q_row_reg[l][COORD_BITS-1], q_row_reg[l]};
            mag  = diff[DF_W-1] ? (~diff + 1'b1) : diff;
            ab1_reg[l] <= dim_active[l] ? mag[COORD_BITS-1:0] : '0;
            sq2_reg[l] <= norm_mode ? SQ_W'(ab1_reg[l])
                                    : SQ_W'(ab1_reg[l]) * SQ_W'(ab1_reg[l]);
            if (cmd.q_row)
            begin
                q_row_reg[l] <= rd_data[l];
            end
        end
    end

    // sum of squares or maximum magnitude
    always_comb
    begin
        acc_comb = '0;
        for (int l = 0; l < MAX_DIMS; l++)
        begin
            if (norm_mode)
            begin
                if (ACC_W'(sq2_reg[l]) > acc_comb)
                begin
                    acc_comb = ACC_W'(sq2_reg[l]);
                end
            end
            else
            begin
                acc_comb = acc_comb + ACC_W'(sq2_reg[l]);
            end
        end
    end

    // smallest distance strictly above the previous rank
    assign take = v3_reg && !skip3_reg && (!have_prev_reg || acc3_reg > prev_reg)
                  && (!hold_valid_reg || acc3_reg < hold_reg);

    assign prev_ext = EXT_W'(prev_reg);
    assign dist_sat = (prev_ext > EXT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                           : prev_ext[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        acc3_reg <= acc_comb;
        if (cmd.q_start)
        begin
            qpt_reg <= point_index;
        end
        if (take)
        begin
            hold_reg <= acc3_reg;
        end
        if (cmd.pass_end)
        begin
            prev_reg <= hold_reg;
        end
        if (cmd.out_load)
        begin
            distance_reg <= cmd.out_found ? dist_sat : {DIST_W{1'b1}};
            found_reg    <= cmd.out_found;
        end
        skip0_reg <= 32'(j_reg) == 32'(qpt_reg);
        skip1_reg <= skip0_reg;
        skip2_reg <= skip1_reg;
        skip3_reg <= skip2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg          <= '0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            hold_valid_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.pass_start)
            begin
                j_reg <= '0;
            end
            else if (cmd.issue)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.q_start)
            begin
                have_prev_reg <= 1'b0;
            end
            else if (cmd.pass_end)
            begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.pass_start)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    assign distance = distance_reg;
    assign found    = found_reg;

endmodule

`default_nettype wire

// ----- design/kth_nearest_neighbor_distance.sv -----
// ---------------------------------------------------------------------------
// kth_nearest_neighbor_distance
// Brute-force k-th distinct nearest-neighbor distance over a loaded point set.
// ---------------------------------------------------------------------------
// A load request writes one coordinate. A query request runs up to k passes;
// each reads the first num_points stored points, one point per cycle, from the
// point store (all dimensions side by side) and then drains the distance
// pipeline; k is k_rank capped at MAX_K and num_points is capped at
// MAX_POINTS. No request is taken while a query runs; the result waits in an
// output register, so a new request can be taken while it is still pending.
// Loads out of range are dropped.
`timescale 1ns / 1ps
`default_nettype none

module kth_nearest_neighbor_distance #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 8,
    parameter int MAX_K      = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // point_index[9:0], dim_index[12:10], coord[28:13]
    input  wire logic        s_tuser,   // op
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // distance[34:0]
    output logic             m_tuser,   // found
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    import knnd_pkg::*;

    logic [10:0] num_points_reg;
    logic [3:0]  num_dims_reg;
    logic [4:0]  k_rank_reg;
    logic        norm_mode_reg;

    knnd_cmd_t    cmd;
    knnd_status_t status;
    logic [DIST_W-1:0] distance;
    logic              found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 11'd2;
            num_dims_reg   <= 4'd1;
            k_rank_reg     <= 5'd1;
            norm_mode_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_POINTS: num_points_reg <= cfg_data;
                CFG_NUM_DIMS:   num_dims_reg   <= cfg_data[3:0];
                CFG_K_RANK:     k_rank_reg     <= cfg_data[4:0];
                CFG_NORM_MODE:  norm_mode_reg  <= cfg_data[0];
            endcase
        end
    end

    knnd_ctrl #(
        .MAX_K (MAX_K)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .k_rank    (k_rank_reg),
        .status    (status),
        .cmd       (cmd)
    );

    knnd_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (s_tvalid && s_tready),
        .in_op       (s_tuser),
        .point_index (s_tdata[9:0]),
        .dim_index   (s_tdata[12:10]),
        .coord       (s_tdata[28:13]),
        .num_points  (num_points_reg),
        .num_dims    (num_dims_reg),
        .k_rank      (k_rank_reg),
        .norm_mode   (norm_mode_reg),
        .cmd         (cmd),
        .status      (status),
        .distance    (distance),
        .found       (found)
    );

    assign m_tdata = {5'd0, distance};
    assign m_tuser = found;

endmodule

`default_nettype wire
